/* rtl/core/bflm_pkg.sv */
// Package for the block free list manager: widths, operation and status codes,
// and the command struct between the controller and the datapath.
// No dependencies.
package bflm_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int PEND_W     = 16;

    localparam int FUNC_W     = 3;
    localparam int IDX_W      = 10;
    localparam int STATUS_W   = 2;
    localparam int FREE_W     = $clog2(NUM_BLOCKS + 1);
    localparam int LINK_W     = $clog2(NUM_BLOCKS) + 1;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);

    // A link equal to the pool size marks the end of the list.
    localparam logic [LINK_W-1:0] INVALID_LINK = LINK_W'(NUM_BLOCKS);
    localparam logic [PEND_W-1:0] PEND_MAX     = {PEND_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC   = 3'd0,
        FN_FREE    = 3'd1,
        FN_MARK    = 3'd2,
        FN_ADD     = 3'd3,
        FN_RELEASE = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_PEND_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic              taken;
        logic              done;
        logic [PEND_W-1:0] pend;
    } t_marks;

    typedef struct packed {
        logic              load;
        logic              commit;
        logic              clr_we;
        logic [ADDR_W-1:0] clr_addr;
    } t_dp_cmd;

endpackage

/* rtl/core/bflm_in_if.sv */
// Request channel of the block free list manager: valid/ready and the request fields.
// Depends on bflm_pkg.
interface bflm_in_if;
    import bflm_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  blk_idx;

    modport source (output valid, output func, output blk_idx, input ready);
    modport sink   (input valid, input func, input blk_idx, output ready);
endinterface

/* rtl/core/bflm_out_if.sv */
// Result channel of the block free list manager: valid/ready and the result fields.
// Depends on bflm_pkg.
interface bflm_out_if;
    import bflm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic                recycled;
    logic [FREE_W-1:0]   free_blocks;

    modport source (output valid, output status, output granted_index,
                    output recycled, output free_blocks, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input recycled, input free_blocks, output ready);
endinterface

/* rtl/core/bflm_ctrl.sv */
// Controller of the block free list manager: clearing sweep, request sequencing
// and result register occupancy. Depends on bflm_pkg.
module bflm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bflm_pkg::t_dp_cmd o_cmd
);
    import bflm_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_out_valid;
    logic              commit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign commit      = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign o_cmd.load     = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.commit   = commit;
    assign o_cmd.clr_we   = (r_state == S_CLEAR);
    assign o_cmd.clr_addr = r_cnt;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_cnt == ADDR_W'(NUM_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/bflm_dp.sv */
// Datapath of the block free list manager: link and mark memories, list pointers,
// free count and the result register. Depends on bflm_pkg.
module bflm_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bflm_pkg::t_dp_cmd         i_cmd,
    input  logic [bflm_pkg::FUNC_W-1:0]   i_func,
    input  logic [bflm_pkg::IDX_W-1:0]    i_blk_idx,
    output logic [bflm_pkg::STATUS_W-1:0] o_status,
    output logic [bflm_pkg::IDX_W-1:0]    o_granted_index,
    output logic                      o_recycled,
    output logic [bflm_pkg::FREE_W-1:0]   o_free_blocks
);
    import bflm_pkg::*;

    // Link of each block, and its marks. The tail's own link is held in
    // r_tail_self rather than read from memory.
    logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
    t_marks            mark_mem [NUM_BLOCKS];

    logic [FUNC_W-1:0] r_func;
    logic [IDX_W-1:0]  r_idx;
    logic [LINK_W-1:0] r_link_rd;
    t_marks            r_mark_rd;

    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic              r_tail_self, n_tail_self;
    logic [FREE_W-1:0] r_free, n_free;

    logic [STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]    r_granted;
    logic                r_recycled;
    logic [FREE_W-1:0]   r_free_out;

    logic [LINK_W-1:0]   head_link;
    logic                idx_ok;
    logic                append;
    logic                link_we;
    logic                mark_we;
    logic [IDX_W-1:0]    mark_addr;
    t_marks              mark_wd;
    t_status             status;
    logic [IDX_W-1:0]    granted;
    logic                recycled;

    always_comb begin
        head_link = r_link_rd;
        if (r_head == r_tail) begin
            head_link = r_tail_self ? {1'b0, r_tail} : INVALID_LINK;
        end
    end

    assign idx_ok = ({1'b0, r_idx} < LINK_W'(NUM_BLOCKS));

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_tail_self = r_tail_self;
        n_free      = r_free;
        append      = 1'b0;
        mark_we     = 1'b0;
        mark_addr   = r_idx;
        mark_wd     = r_mark_rd;
        status      = ST_DONE;
        granted     = '0;
        recycled    = 1'b0;

        case (r_func)
            FN_ALLOC: begin
                if ((r_free <= FREE_W'(1)) || (head_link >= INVALID_LINK)) begin
                    status = ST_REFUSED;
                end else begin
                    n_head    = head_link[IDX_W-1:0];
                    n_free    = r_free - 1'b1;
                    mark_we   = 1'b1;
                    mark_addr = r_head;
                    mark_wd   = '0;
                    granted   = r_head;
                end
            end
            FN_FREE: begin
                append = idx_ok;
            end
            FN_MARK: begin
                if (idx_ok) begin
                    mark_we      = 1'b1;
                    mark_wd.done = 1'b1;
                    if ((r_mark_rd.pend == '0) && !r_mark_rd.taken) begin
                        mark_wd.taken = 1'b1;
                        recycled      = 1'b1;
                        append        = 1'b1;
                    end
                end
            end
            FN_ADD: begin
                if (idx_ok) begin
                    if (r_mark_rd.pend == PEND_MAX) begin
                        status = ST_PEND_ERR;
                    end else begin
                        mark_we      = 1'b1;
                        mark_wd.pend = r_mark_rd.pend + 1'b1;
                    end
                end
            end
            FN_RELEASE: begin
                if (idx_ok) begin
                    if (r_mark_rd.pend == '0) begin
                        status = ST_PEND_ERR;
                    end else begin
                        mark_we      = 1'b1;
                        mark_wd.pend = r_mark_rd.pend - 1'b1;
                        if ((r_mark_rd.pend == PEND_W'(1)) && r_mark_rd.done
                                && !r_mark_rd.taken) begin
                            mark_wd.taken = 1'b1;
                            recycled      = 1'b1;
                            append        = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (append) begin
            n_tail      = r_idx;
            n_tail_self = (r_idx == r_tail);
            if (r_free < FREE_W'(NUM_BLOCKS)) begin
                n_free = r_free + 1'b1;
            end
        end
    end

    assign link_we = append;

    // Memories: clearing sweep after reset, reads on request, writes on commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_we) begin
            link_mem[i_cmd.clr_addr] <= {1'b0, i_cmd.clr_addr} + LINK_W'(1);
            mark_mem[i_cmd.clr_addr] <= '0;
        end else if (i_cmd.commit) begin
            if (link_we) begin
                link_mem[r_tail] <= {1'b0, r_idx};
            end
            if (mark_we) begin
                mark_mem[mark_addr] <= mark_wd;
            end
        end
        if (i_cmd.load) begin
            r_link_rd <= link_mem[r_head];
            r_mark_rd <= mark_mem[i_blk_idx];
            r_func    <= i_func;
            r_idx     <= i_blk_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= IDX_W'(NUM_BLOCKS - 1);
            r_tail_self <= 1'b0;
            r_free      <= FREE_W'(NUM_BLOCKS);
        end else if (i_cmd.commit) begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_tail_self <= n_tail_self;
            r_free      <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status   <= status;
            r_granted  <= granted;
            r_recycled <= recycled;
            r_free_out <= n_free;
        end
    end

    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_recycled      = r_recycled;
    assign o_free_blocks   = r_free_out;

endmodule

/* rtl/core/block_free_list_manager_top.sv */
// Top level of the block free list manager: joins the controller and the datapath
// to the request and result channels. Depends on bflm_pkg, bflm_in_if, bflm_out_if.
//
// The block manages a pool of 1024 fixed-size blocks whose free entries form a
// first-in first-out linked list. Each request transfer carries an operation
// (allocate, free, mark write complete, add or release a pending reference)
// and a block index, and produces exactly one result transfer with a status,
// the granted block, a recycle flag and the free count after the operation.
// After reset the block runs a clearing sweep over all 1024 entries, one memory entry
// per cycle, during which no request is accepted. After that, in the cycle of a
// request's transfer the link memory is read at the list head and the mark memory
// at the addressed block; then, in the execute state and once the result register
// is free or being taken, the operation is worked out, both memories are written
// back and the result register is loaded, and the block is ready again in the cycle
// after. The read-then-write turn round the single-port memories is why no request is
// taken while another is in flight. The result register is one deep, so a new request
// is taken while an earlier result still waits; the operation then holds until that
// result is taken. Allocation is refused while one block or fewer is free, so one
// block always remains in the list.
module block_free_list_manager_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bflm_in_if.sink     i_in,
    bflm_out_if.source  o_out
);
    import bflm_pkg::*;

    t_dp_cmd w_cmd;

    bflm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    bflm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_func          (i_in.func),
        .i_blk_idx       (i_in.blk_idx),
        .o_status        (o_out.status),
        .o_granted_index (o_out.granted_index),
        .o_recycled      (o_out.recycled),
        .o_free_blocks   (o_out.free_blocks)
    );

    // A request transfer is never followed directly by another one.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted in the cycle after a request transfer");

    // Every committed operation presents a result in the next cycle.
    a_commit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out.valid)
        else $error("committed operation did not present a result");

    // No request is accepted during the clearing sweep.
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_we |-> !i_in.ready)
        else $error("request ready during the clearing sweep");

    // A recycle only comes with a completed operation, and a failed one grants nothing.
    a_result_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.recycled || (o_out.status != ST_DONE)))
            |-> ((o_out.granted_index == '0)
                 && !(o_out.recycled && (o_out.status != ST_DONE))))
        else $error("inconsistent result fields");

endmodule

/* tb/sv/block_free_list_manager_top_tb.sv */
// Self-checking testbench for block_free_list_manager_top: directed table and paced
// random traffic, checked against a local predictor or the typed table results.
// Depends on bflm_pkg, bflm_in_if, bflm_out_if and the block itself.
module block_free_list_manager_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bflm_pkg::*;

    // Operation codes the block does not define; they must leave the pool untouched.
    localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 8;
    localparam int PHASE_ITEMS  = 130;

    // What one result transfer should carry.
    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   granted;
        logic               recycled;
        logic [FREE_W-1:0]  free_blocks;
    } t_outcome;

    localparam t_outcome NO_TYPED = '0;

    // One row of the directed part. Where typed is set, res holds the result read
    // straight off the behaviour; otherwise the predictor supplies it.
    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [IDX_W-1:0]  idx;
        bit                typed;
        t_outcome          res;
    } t_script_row;

    localparam int N_SCRIPT = 24;

    t_script_row script [N_SCRIPT] = '{
        // Fresh pool: the head block 0 goes first, then block 1.
        '{FN_ALLOC,     10'd0,    1'b1, '{ST_DONE, 10'd0, 1'b0, 11'd1023}},
        '{FN_ALLOC,     10'd1023, 1'b1, '{ST_DONE, 10'd1, 1'b0, 11'd1022}},
        // Marking a block with no references recycles it, but only the first time.
        '{FN_MARK,      10'd0,    1'b1, '{ST_DONE, 10'd0, 1'b1, 11'd1023}},
        '{FN_MARK,      10'd0,    1'b1, '{ST_DONE, 10'd0, 1'b0, 11'd1023}},
        // A pending reference holds the block back until it is released.
        '{FN_ADD,       10'd1,    1'b1, '{ST_DONE, 10'd0, 1'b0, 11'd1023}},
        '{FN_MARK,      10'd1,    1'b0, NO_TYPED},
        '{FN_RELEASE,   10'd1,    1'b0, NO_TYPED},
        // Releasing at zero is an underflow.
        '{FN_RELEASE,   10'd1,    1'b1, '{ST_PEND_ERR, 10'd0, 1'b0, 11'd1024}},
        // Direct free of the tail block with a full pool: the count saturates.
        '{FN_FREE,      10'd1,    1'b1, '{ST_DONE, 10'd0, 1'b0, 11'd1024}},
        // Undefined operations do nothing.
        '{FN_SPARE_LO,  10'd1023, 1'b1, '{ST_DONE, 10'd0, 1'b0, 11'd1024}},
        '{FN_SPARE_MID, 10'h2AA,  1'b1, '{ST_DONE, 10'd0, 1'b0, 11'd1024}},
        '{FN_SPARE_HI,  10'h155,  1'b1, '{ST_DONE, 10'd0, 1'b0, 11'd1024}},
        // References on a block that sits in the free list and was never marked.
        '{FN_ADD,       10'd1023, 1'b0, NO_TYPED},
        '{FN_ADD,       10'd1023, 1'b0, NO_TYPED},
        '{FN_RELEASE,   10'd1023, 1'b0, NO_TYPED},
        '{FN_RELEASE,   10'd1023, 1'b0, NO_TYPED},
        '{FN_RELEASE,   10'd1023, 1'b1, '{ST_PEND_ERR, 10'd0, 1'b0, 11'd1024}},
        // Two more grants, then one block freed directly with a reference still
        // outstanding and the other recycled once marked and released. This also
        // mends the self-link that the tail free above left behind.
        '{FN_ALLOC,     10'h3FF,  1'b0, NO_TYPED},
        '{FN_ALLOC,     10'd0,    1'b0, NO_TYPED},
        '{FN_ADD,       10'd2,    1'b0, NO_TYPED},
        '{FN_ADD,       10'd3,    1'b0, NO_TYPED},
        '{FN_MARK,      10'd3,    1'b0, NO_TYPED},
        '{FN_FREE,      10'd2,    1'b0, NO_TYPED},
        '{FN_RELEASE,   10'd3,    1'b0, NO_TYPED}
    };

    logic i_clk;
    logic i_rst_n;

    bflm_in_if  req_ch ();
    bflm_out_if res_ch ();

    block_free_list_manager_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // Predictor copy of the pool: list links, head, tail, free count and per-block marks.
    logic [LINK_W-1:0] pool_link [NUM_BLOCKS];
    logic [ADDR_W-1:0] pool_head;
    logic [ADDR_W-1:0] pool_tail;
    logic [FREE_W-1:0] pool_free;
    logic [PEND_W-1:0] pool_pend [NUM_BLOCKS];
    bit                pool_done [NUM_BLOCKS];
    bit                pool_claimed [NUM_BLOCKS];

    t_outcome         due_outcomes [$];   // results still owed by the block, oldest first
    logic [IDX_W-1:0] owned_blocks [$];   // blocks granted and not yet handed back
    int               send_gap_pct;
    int               sink_stall_pct;
    int               items_sent;
    int               n_fail;
    int unsigned      cycle_count;

    // Append a block at the tail of the free list. When the block is already the
    // tail it ends up linked to itself, exactly as the hardware does it.
    function automatic void append_block(input logic [ADDR_W-1:0] b);
        pool_link[b]         = INVALID_LINK;
        pool_link[pool_tail] = LINK_W'(b);
        pool_tail            = b;
        if (pool_free < FREE_W'(NUM_BLOCKS))
            pool_free++;
    endfunction

    function automatic logic try_reclaim(input logic [ADDR_W-1:0] b);
        if (pool_pend[b] != '0 || !pool_done[b] || pool_claimed[b])
            return 1'b0;
        pool_claimed[b] = 1'b1;
        append_block(b);
        return 1'b1;
    endfunction

    // Apply one request to the predictor's pool and return the result it owes.
    function automatic t_outcome pool_step(input logic [FUNC_W-1:0] fn,
                                           input logic [ADDR_W-1:0] b);
        t_outcome          o;
        logic [ADDR_W-1:0] h;
        o        = '0;
        o.status = ST_DONE;
        case (fn)
            FN_ALLOC: begin
                h = pool_head;
                if (pool_free <= 1 || pool_link[h] >= LINK_W'(NUM_BLOCKS)) begin
                    o.status = ST_REFUSED;
                end else begin
                    pool_head       = pool_link[h][ADDR_W-1:0];
                    pool_free--;
                    pool_done[h]    = 1'b0;
                    pool_pend[h]    = '0;
                    pool_claimed[h] = 1'b0;
                    o.granted       = h;
                end
            end
            FN_FREE: begin
                append_block(b);
            end
            FN_MARK: begin
                pool_done[b] = 1'b1;
                o.recycled   = try_reclaim(b);
            end
            FN_ADD: begin
                if (pool_pend[b] == PEND_MAX)
                    o.status = ST_PEND_ERR;
                else
                    pool_pend[b]++;
            end
            FN_RELEASE: begin
                if (pool_pend[b] == '0) begin
                    o.status = ST_PEND_ERR;
                end else begin
                    pool_pend[b]--;
                    if (pool_pend[b] == '0)
                        o.recycled = try_reclaim(b);
                end
            end
            default: ;
        endcase
        o.free_blocks = pool_free;
        return o;
    endfunction

    // Offer one request, with a random gap first when the sender is pacing, and
    // wait for its transfer. The prediction is made at the edge of the transfer, in
    // this process, so that the choice of the next request can rely on it.
    task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                                 input bit typed, input t_outcome typed_res);
        t_outcome got;
        bit       known;
        while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.func    <= fn;
        req_ch.blk_idx <= idx;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);

        got = pool_step(fn, idx);
        due_outcomes.push_back(typed ? typed_res : got);
        items_sent++;

        // Keep track of which blocks the traffic generator may work on.
        if (fn == FN_ALLOC && got.status == ST_DONE) begin
            known = 1'b0;
            foreach (owned_blocks[k])
                if (owned_blocks[k] == got.granted)
                    known = 1'b1;
            if (!known)
                owned_blocks.push_back(got.granted);
        end
        if (got.recycled || fn == FN_FREE) begin
            for (int k = owned_blocks.size() - 1; k >= 0; k--)
                if (owned_blocks[k] == idx)
                    owned_blocks.delete(k);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // The result side takes transfers at random, stalling at the current rate.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Every result transfer is held against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (due_outcomes.size() == 0) begin
                $error("result transfer with no request outstanding");
                n_fail++;
            end else begin
                want = due_outcomes.pop_front();
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_ch.status);
                    n_fail++;
                end
                if (res_ch.granted_index !== want.granted) begin
                    $error("granted_index: expected %0d, got %0d",
                           want.granted, res_ch.granted_index);
                    n_fail++;
                end
                if (res_ch.recycled !== want.recycled) begin
                    $error("recycled: expected %0d, got %0d", want.recycled, res_ch.recycled);
                    n_fail++;
                end
                if (res_ch.free_blocks !== want.free_blocks) begin
                    $error("free_blocks: expected %0d, got %0d",
                           want.free_blocks, res_ch.free_blocks);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int               gap_by_phase [4];
        int               stall_by_phase [4];
        int               phase_end;
        int               pick;
        int               refs;
        int               mark_at;
        logic [IDX_W-1:0] b;

        gap_by_phase   = '{0, 47, 0, 21};
        stall_by_phase = '{0, 0, 47, 21};

        send_gap_pct   = 0;
        sink_stall_pct = 0;
        items_sent     = 0;
        n_fail         = 0;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.func    = FN_ALLOC;
        req_ch.blk_idx = '0;

        // The predictor starts from the reset pool: every block free, linked in order.
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            pool_link[i]    = (i + 1 < NUM_BLOCKS) ? LINK_W'(i + 1) : INVALID_LINK;
            pool_pend[i]    = '0;
            pool_done[i]    = 1'b0;
            pool_claimed[i] = 1'b0;
        end
        pool_head = '0;
        pool_tail = ADDR_W'(NUM_BLOCKS - 1);
        pool_free = FREE_W'(NUM_BLOCKS);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. The clearing sweep after reset is covered by simply
        // waiting for the first request transfer.
        foreach (script[r])
            issue_request(script[r].fn, script[r].idx, script[r].typed, script[r].res);

        // Random traffic in four pacing phases: grants, and block lifetimes on granted blocks
        // (references taken, write marked, references dropped until recycle). The rest is
        // direct frees and unconstrained requests.
        for (int p = 0; p < 4; p++) begin
            send_gap_pct   = gap_by_phase[p];
            sink_stall_pct = stall_by_phase[p];
            phase_end      = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 30 || (owned_blocks.size() == 0 && pick < 80)) begin
                    issue_request(FN_ALLOC, IDX_W'($urandom_range(0, NUM_BLOCKS - 1)),
                                  1'b0, NO_TYPED);
                end else if (pick < 65) begin
                    b       = owned_blocks[$urandom_range(0, owned_blocks.size() - 1)];
                    refs    = $urandom_range(0, 3);
                    mark_at = $urandom_range(0, refs);
                    repeat (refs)
                        issue_request(FN_ADD, b, 1'b0, NO_TYPED);
                    for (int j = 0; j <= refs; j++) begin
                        if (j == mark_at)
                            issue_request(FN_MARK, b, 1'b0, NO_TYPED);
                        if (j < refs)
                            issue_request(FN_RELEASE, b, 1'b0, NO_TYPED);
                    end
                    // Now and then one release too many, to hit the underflow.
                    if ($urandom_range(0, 3) == 0)
                        issue_request(FN_RELEASE, b, 1'b0, NO_TYPED);
                end else if (pick < 80) begin
                    b = owned_blocks[$urandom_range(0, owned_blocks.size() - 1)];
                    issue_request(FN_FREE, b, 1'b0, NO_TYPED);
                end else begin
                    issue_request(FUNC_W'($urandom_range(0, FN_SPARE_HI)),
                                  IDX_W'($urandom_range(0, NUM_BLOCKS - 1)), 1'b0, NO_TYPED);
                end
            end
        end
        req_ch.valid <= 1'b0;

        // Let every owed result arrive, then watch on for strays before the verdict.
        while (due_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
